// ===== design/lex_pair_shell_sort_core_defines.svh =====
// Assertion macros shared by the sort core.
`ifndef LEX_PAIR_SHELL_SORT_CORE_DEFINES_SVH
`define LEX_PAIR_SHELL_SORT_CORE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define LPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lps_pkg.sv =====
package lps_pkg;

    localparam int unsigned GapCount = 12;

    typedef enum logic [3:0] {
        t_idle_st,
        t_gapsel_st,
        t_outer_st,
        t_rdk_st,
        t_wtk_st,
        t_rdj_st,
        t_wtj_st,
        t_cmp_st,
        t_ins_st,
        t_rdout_st,
        t_rdwait_st
    } t_state;

    localparam logic [0:0] ActLoad = 1'b0;
    localparam logic [0:0] ActRead = 1'b1;

    function automatic logic [31:0] gap_value(input logic [3:0] idx);
        logic [31:0] g;
        begin
            unique case (idx)
                4'd0:  g = 32'd1;
                4'd1:  g = 32'd5;
                4'd2:  g = 32'd19;
                4'd3:  g = 32'd41;
                4'd4:  g = 32'd109;
                4'd5:  g = 32'd209;
                4'd6:  g = 32'd505;
                4'd7:  g = 32'd929;
                4'd8:  g = 32'd2161;
                4'd9:  g = 32'd3905;
                4'd10: g = 32'd8929;
                4'd11: g = 32'd16001;
                default: g = 32'd0;
            endcase
            return g;
        end
    endfunction

endpackage

// ===== design/lps_in_if.sv =====
interface lps_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  action;
    logic [19:0] row_index;
    logic [19:0] col_index;
    logic [63:0] value_bits;
    logic [9:0]  source_offset;
    logic [0:0]  last_element;
    modport source (output valid, action, row_index, col_index, value_bits,
                    source_offset, last_element, input ready);
    modport sink (input valid, action, row_index, col_index, value_bits,
                  source_offset, last_element, output ready);
endinterface

// ===== design/lps_out_if.sv =====
interface lps_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] sorted_row;
    logic [19:0] sorted_col;
    logic [63:0] sorted_value;
    logic [9:0]  mapped_offset;
    logic [0:0]  equality_tag;
    logic [0:0]  last_result;
    modport source (output valid, sorted_row, sorted_col, sorted_value, mapped_offset,
                    equality_tag, last_result, input ready);
    modport sink (input valid, sorted_row, sorted_col, sorted_value, mapped_offset,
                  equality_tag, last_result, output ready);
endinterface

// ===== design/lps_cfg_if.sv =====
interface lps_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== design/lex_pair_shell_sort_core.sv =====
// Sorting sparse-matrix entry loader. Loads (action 0) are taken one per cycle while idle with
// no result waiting, and are stored at the next free slot, if any, of an entry memory with one
// write and one read port. A load with last_element set starts an in-place Shell sort on the
// (row, column) key, and the input is not ready while it runs. One sequencer drives the sort
// around one key comparator and the memory. A read sets the address, then takes the registered
// data in a wait state; a write needs no wait. Gap selection steps through the gap table while
// the gaps fit. Each gap pass starts from the outer state and returns to it. Each insertion
// step reads entry k, then reads and compares the entry a gap back until the key is not less or
// the walk reaches the front, then writes the held entry. An entry that moves is written in its
// compare cycle. A read request (action 1) fetches the next sorted entry through the registered
// read data and a wait state into the output register. A read before a sort or past the last
// entry gives no result. While a result waits in the output register, no request of either
// kind is taken. The next request is taken in the cycle in which the result is accepted.
`include "lex_pair_shell_sort_core_defines.svh"
module lex_pair_shell_sort_core #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned INDEX_WIDTH = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lps_in_if.sink    in_ch,
    lps_out_if.source out_ch,
    lps_cfg_if.sink   cfg_ch
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] row;
        logic [INDEX_WIDTH-1:0] col;
        logic [63:0]            val;
        logic [9:0]             off;
    } t_entry;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;
    t_entry r_hold, n_hold;
    t_entry r_jent, n_jent;
    t_entry r_odata, n_odata;

    lps_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_sorted, n_sorted;
    logic [0:0]    r_eq;
    logic [3:0]    r_top, n_top;
    logic [CW-1:0] r_gap, n_gap;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_j, n_j;
    logic          r_ovalid, n_ovalid;
    logic          r_olast, n_olast;
    logic          r_rdlast, n_rdlast;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata;
    logic          in_fire, out_free, key_less;
    logic [31:0]   gap_top;
    logic [CW:0]   jm;

    assign out_free = !r_ovalid || out_ch.ready;
    assign in_ch.ready = (r_state == lps_pkg::t_idle_st) && out_free;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign gap_top  = lps_pkg::gap_value(r_top);
    assign jm       = {1'b0, r_j} - {1'b0, r_gap};
    assign key_less = (r_hold.row < r_jent.row) ||
                      ((r_hold.row == r_jent.row) && (r_hold.col < r_jent.col));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lps_pkg::t_idle_st;
            r_count  <= '0;
            r_ptr    <= '0;
            r_sorted <= 1'b0;
            r_eq     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_sorted <= n_sorted;
            r_ovalid <= n_ovalid;
            if (cfg_ch.valid) begin
                r_eq <= cfg_ch.data;
            end
        end
        r_top    <= n_top;
        r_gap    <= n_gap;
        r_k      <= n_k;
        r_j      <= n_j;
        r_hold   <= n_hold;
        r_jent   <= n_jent;
        r_odata  <= n_odata;
        r_olast  <= n_olast;
        r_rdlast <= n_rdlast;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_sorted = r_sorted;
        n_top    = r_top;
        n_gap    = r_gap;
        n_k      = r_k;
        n_j      = r_j;
        n_hold   = r_hold;
        n_jent   = r_jent;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_rdlast = r_rdlast;
        n_ovalid = r_ovalid && !out_ch.ready;
        we       = 1'b0;
        waddr    = r_count[AW-1:0];
        raddr    = r_k[AW-1:0];
        wdata    = r_hold;
        unique case (r_state)
            lps_pkg::t_idle_st: begin
                if (in_fire) begin
                    if (in_ch.action == lps_pkg::ActLoad) begin
                        n_count = r_sorted ? '0 : r_count;
                        n_ptr = r_sorted ? '0 : r_ptr;
                        n_sorted = 1'b0;
                        waddr = n_count[AW-1:0];
                        wdata.row = in_ch.row_index[INDEX_WIDTH-1:0];
                        wdata.col = in_ch.col_index[INDEX_WIDTH-1:0];
                        wdata.val = in_ch.value_bits;
                        wdata.off = in_ch.source_offset;
                        if (n_count < CW'(MAX_ENTRIES)) begin
                            we = 1'b1;
                            n_count = n_count + 1'b1;
                        end
                        if (in_ch.last_element[0]) begin
                            n_top = '0;
                            n_state = lps_pkg::t_gapsel_st;
                        end
                    end else if (r_sorted && (r_ptr < r_count)) begin
                        raddr = r_ptr[AW-1:0];
                        n_rdlast = (r_ptr + 1'b1) == r_count;
                        n_ptr = r_ptr + 1'b1;
                        n_state = lps_pkg::t_rdwait_st;
                    end
                end
            end
            lps_pkg::t_gapsel_st: begin
                // Find how many gaps are at most half the count, one table entry a cycle.
                if ((r_top < 4'(lps_pkg::GapCount)) &&
                    (gap_top <= 32'(r_count >> 1))) begin
                    n_top = r_top + 1'b1;
                end else begin
                    n_state = lps_pkg::t_outer_st;
                end
            end
            lps_pkg::t_outer_st: begin
                if (r_top == '0) begin
                    n_sorted = 1'b1;
                    n_ptr = '0;
                    n_state = lps_pkg::t_idle_st;
                end else begin
                    n_gap = CW'(lps_pkg::gap_value(r_top - 1'b1));
                    n_k = CW'(lps_pkg::gap_value(r_top - 1'b1));
                    n_top = r_top - 1'b1;
                    n_state = lps_pkg::t_rdk_st;
                end
            end
            lps_pkg::t_rdk_st: begin
                if (r_k >= r_count) begin
                    n_state = lps_pkg::t_outer_st;
                end else begin
                    raddr = r_k[AW-1:0];
                    n_j = r_k;
                    n_state = lps_pkg::t_wtk_st;
                end
            end
            lps_pkg::t_wtk_st: begin
                n_hold = r_rd;
                n_state = lps_pkg::t_rdj_st;
            end
            lps_pkg::t_rdj_st: begin
                if (r_j >= r_gap) begin
                    raddr = jm[AW-1:0];
                    n_state = lps_pkg::t_wtj_st;
                end else begin
                    n_state = lps_pkg::t_ins_st;
                end
            end
            lps_pkg::t_wtj_st: begin
                n_jent = r_rd;
                n_state = lps_pkg::t_cmp_st;
            end
            lps_pkg::t_cmp_st: begin
                if (key_less) begin
                    we = 1'b1;
                    waddr = r_j[AW-1:0];
                    wdata = r_jent;
                    n_j = jm[CW-1:0];
                    n_state = lps_pkg::t_rdj_st;
                end else begin
                    n_state = lps_pkg::t_ins_st;
                end
            end
            lps_pkg::t_ins_st: begin
                we = 1'b1;
                waddr = r_j[AW-1:0];
                wdata = r_hold;
                n_k = r_k + 1'b1;
                n_state = lps_pkg::t_rdk_st;
            end
            lps_pkg::t_rdwait_st: begin
                // The fetched entry moves to the output register so the memory read port stays free.
                n_ovalid = 1'b1;
                n_odata = r_rd;
                n_olast = r_rdlast;
                n_state = lps_pkg::t_idle_st;
            end
            default: n_state = lps_pkg::t_idle_st;
        endcase
    end

    assign out_ch.valid         = r_ovalid;
    assign out_ch.sorted_row    = 20'(r_odata.row);
    assign out_ch.sorted_col    = 20'(r_odata.col);
    assign out_ch.sorted_value  = r_odata.val;
    assign out_ch.mapped_offset = r_odata.off;
    assign out_ch.equality_tag  = r_eq;
    assign out_ch.last_result   = r_olast;

    `LPS_ASSERT_IMPLY(a_no_ready_in_sort, i_clk, i_rst_n,
        r_state != lps_pkg::t_idle_st, !in_ch.ready, "input ready outside idle")
    `LPS_ASSERT_NEXT(a_result_after_fetch, i_clk, i_rst_n,
        r_state == lps_pkg::t_rdwait_st, out_ch.valid, "fetched entry not presented")
    `LPS_ASSERT_IMPLY(a_ptr_in_range, i_clk, i_rst_n,
        1'b1, r_ptr <= r_count, "read pointer past count")
    `LPS_ASSERT_IMPLY(a_count_in_range, i_clk, i_rst_n,
        1'b1, r_count <= CW'(MAX_ENTRIES), "entry count overflow")

endmodule
